// ===== design/srq_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted request queue package
// Shared field widths, operation and status codes, word types and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package srq_pkg;

    localparam int OP_W  = 3;
    localparam int TAG_W = 8;
    localparam int SEC_W = 48;
    localparam int LEN_W = 16;
    localparam int KEY_W = 49;
    localparam int ST_W  = 2;
    localparam int OCC_W = 6;

    localparam logic [OP_W-1:0] OP_ADD      = 3'd0;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE   = 3'd2;
    localparam logic [OP_W-1:0] OP_FORMER   = 3'd3;
    localparam logic [OP_W-1:0] OP_LATTER   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK     = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [ST_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [TAG_W-1:0] request_tag;
        logic [SEC_W-1:0] start_sector;
        logic [LEN_W-1:0] length_sectors;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [TAG_W-1:0] result_tag;
        logic [SEC_W-1:0] result_sector;
        logic [OCC_W-1:0] occupancy;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [SEC_W-1:0] start;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [1:0] {
        RD_IDX,
        RD_PREV,
        RD_NEXT
    } rd_sel_t;

    typedef struct packed {
        logic            capture;
        logic            idx_load_count;
        logic            idx_inc;
        logic            idx_dec;
        logic            rd_en;
        rd_sel_t         rd_sel;
        logic            wr_en;
        logic            wr_new;
        logic            cnt_inc;
        logic            cnt_dec;
        logic            save_prev;
        logic            res_tag_rd;
        logic            res_sec_rd;
        logic            res_tag_prev;
        logic            finish;
        logic [ST_W-1:0] fin_status;
    } ctl_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] operation;
        logic            empty;
        logic            full;
        logic            idx_zero;
        logic            idx_top;
        logic            idx_end;
        logic            key_gt;
        logic            tag_eq;
    } dp_stat_t;

endpackage

// ===== design/sorted_request_queue_unit.sv =====
// ----------------------------------------------------------------------------
// Sorted request queue unit
// Bounded queue of disk requests kept in ascending end-sector order, with
// add, dispatch, remove by tag and neighbor lookup.
// ----------------------------------------------------------------------------
// A word is taken at a rising edge where start is high and busy is low. Its
// result is on result for exactly one cycle with done high, and the receiver
// cannot stall it. busy is already low in that result cycle, so the next word
// may be taken there. All entry traffic goes through one memory port with
// registered read data, so each entry walked takes a read and a compare or
// write state. A full add, an empty queue or an unused operation finishes
// straight from the decode state. An add takes longer with each entry it moves
// up, a dispatch or remove with each entry held, and a lookup with the position
// of its tag. The worst case is a remove on a full queue.
module sorted_request_queue_unit #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  srq_pkg::req_t request,
    output logic          done,
    output srq_pkg::rsp_t result
);

    srq_pkg::ctl_cmd_t cmd;
    srq_pkg::dp_stat_t stat;

    srq_controller u_controller (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    srq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .stat    (stat),
        .done    (done),
        .result  (result)
    );

endmodule

// ===== design/srq_datapath.sv =====
// ----------------------------------------------------------------------------
// Sorted request queue datapath
// Entry memory, walk index, entry count, request and result registers.
// ----------------------------------------------------------------------------
module srq_datapath #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  srq_pkg::req_t     request,
    input  srq_pkg::ctl_cmd_t cmd,
    output srq_pkg::dp_stat_t stat,
    output logic              done,
    output srq_pkg::rsp_t     result
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W = srq_pkg::OCC_W;
    localparam int KEY_W = srq_pkg::KEY_W;

    srq_pkg::entry_t             mem [QUEUE_DEPTH];
    srq_pkg::entry_t             rd_data_reg;
    srq_pkg::entry_t             wr_data;
    srq_pkg::req_t               req_reg;
    logic [KEY_W-1:0]            key_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [srq_pkg::TAG_W-1:0]   prev_tag_reg;
    logic [srq_pkg::TAG_W-1:0]   res_tag_reg;
    logic [srq_pkg::SEC_W-1:0]   res_sec_reg;
    logic                        done_reg;
    srq_pkg::rsp_t               result_reg;
    logic [CNT_W-1:0]            rd_cnt;
    logic [IDX_W-1:0]            rd_addr;
    logic [IDX_W-1:0]            wr_addr;
    logic [CNT_W:0]              idx_plus_one;

    always_comb
    begin
        case (cmd.rd_sel)
            srq_pkg::RD_PREV: rd_cnt = idx_reg - CNT_W'(1);
            srq_pkg::RD_NEXT: rd_cnt = idx_reg + CNT_W'(1);
            default:          rd_cnt = idx_reg;
        endcase
    end

    assign rd_addr      = rd_cnt[IDX_W-1:0];
    assign wr_addr      = idx_reg[IDX_W-1:0];
    assign idx_plus_one = {1'b0, idx_reg} + (CNT_W + 1)'(1);

    always_comb
    begin
        if (cmd.wr_new)
        begin
            wr_data.key   = key_reg;
            wr_data.start = req_reg.start_sector;
            wr_data.tag   = req_reg.request_tag;
        end
        else
        begin
            wr_data = rd_data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg      <= request;
            key_reg      <= KEY_W'(request.start_sector) + KEY_W'(request.length_sectors);
            idx_reg      <= '0;
            prev_tag_reg <= '0;
            res_tag_reg  <= '0;
            res_sec_reg  <= '0;
        end
        else
        begin
            if (cmd.idx_load_count)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CNT_W'(1);
            end
            if (cmd.save_prev)
            begin
                prev_tag_reg <= rd_data_reg.tag;
            end
            if (cmd.res_tag_rd)
            begin
                res_tag_reg <= rd_data_reg.tag;
            end
            else if (cmd.res_tag_prev)
            begin
                res_tag_reg <= prev_tag_reg;
            end
            if (cmd.res_sec_rd)
            begin
                res_sec_reg <= rd_data_reg.start;
            end
        end
        if (cmd.finish)
        begin
            result_reg.status        <= cmd.fin_status;
            result_reg.result_tag    <= res_tag_reg;
            result_reg.result_sector <= res_sec_reg;
            result_reg.occupancy     <= OCC_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (cmd.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign stat.operation = req_reg.operation;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign stat.idx_zero  = (idx_reg == '0);
    assign stat.idx_top   = (idx_plus_one >= {1'b0, count_reg});
    assign stat.idx_end   = (idx_reg >= count_reg);
    assign stat.key_gt    = (rd_data_reg.key > key_reg);
    assign stat.tag_eq    = (rd_data_reg.tag == req_reg.request_tag);

    assign done   = done_reg;
    assign result = result_reg;

    // The count never goes past the depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // An insert only happens while there is room.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_inc |-> (count_reg < CNT_W'(QUEUE_DEPTH)) && !cmd.cnt_dec)
        else $error("insert into a full queue");

    // Every write lands inside the memory.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.wr_en |-> (idx_reg < CNT_W'(QUEUE_DEPTH)))
        else $error("write index out of range");

    // A removal only happens when something is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cnt_dec |-> (count_reg != '0))
        else $error("removal from an empty queue");

endmodule

// ===== design/srq_controller.sv =====
// ----------------------------------------------------------------------------
// Sorted request queue controller
// Sequences inserts, pops, tag searches and shifts over the entry memory.
// ----------------------------------------------------------------------------
module srq_controller (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  srq_pkg::dp_stat_t stat,
    output srq_pkg::ctl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ADD_CHK,
        S_ADD_CMP,
        S_DISP_WAIT,
        S_DROP_CHK,
        S_DROP_WR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_NEXT_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = srq_pkg::RD_IDX;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.operation == srq_pkg::OP_ADD)
                begin
                    if (stat.full)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = srq_pkg::ST_FULL;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_load_count = 1'b1;
                        state_next         = S_ADD_CHK;
                    end
                end
                else if (stat.operation == srq_pkg::OP_DISPATCH ||
                         stat.operation == srq_pkg::OP_REMOVE ||
                         stat.operation == srq_pkg::OP_FORMER ||
                         stat.operation == srq_pkg::OP_LATTER)
                begin
                    if (stat.empty)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = srq_pkg::ST_EMPTY;
                        state_next     = S_IDLE;
                    end
                    else if (stat.operation == srq_pkg::OP_DISPATCH)
                    begin
                        cmd.rd_en  = 1'b1;
                        state_next = S_DISP_WAIT;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = srq_pkg::ST_OK;
                    state_next     = S_IDLE;
                end
            end
            S_ADD_CHK:
            begin
                if (stat.idx_zero)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srq_pkg::RD_PREV;
                    state_next = S_ADD_CMP;
                end
            end
            S_ADD_CMP:
            begin
                cmd.wr_en = 1'b1;
                if (stat.key_gt)
                begin
                    cmd.idx_dec = 1'b1;
                    state_next  = S_ADD_CHK;
                end
                else
                begin
                    cmd.wr_new  = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_DISP_WAIT:
            begin
                cmd.res_tag_rd = 1'b1;
                cmd.res_sec_rd = 1'b1;
                state_next     = S_DROP_CHK;
            end
            S_DROP_CHK:
            begin
                if (stat.idx_top)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_FIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = srq_pkg::RD_NEXT;
                    state_next = S_DROP_WR;
                end
            end
            S_DROP_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.idx_inc = 1'b1;
                state_next  = S_DROP_CHK;
            end
            S_SCAN_RD:
            begin
                if (stat.idx_end)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = srq_pkg::ST_ABSENT;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (!stat.tag_eq)
                begin
                    cmd.save_prev = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = S_SCAN_RD;
                end
                else if (stat.operation == srq_pkg::OP_REMOVE)
                begin
                    state_next = S_DROP_CHK;
                end
                else if (stat.operation == srq_pkg::OP_FORMER)
                begin
                    if (stat.idx_zero)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = srq_pkg::ST_ABSENT;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.res_tag_prev = 1'b1;
                        state_next       = S_FIN;
                    end
                end
                else
                begin
                    if (stat.idx_top)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = srq_pkg::ST_ABSENT;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = srq_pkg::RD_NEXT;
                        state_next = S_NEXT_WAIT;
                    end
                end
            end
            S_NEXT_WAIT:
            begin
                cmd.res_tag_rd = 1'b1;
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = srq_pkg::ST_OK;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    // A word is only taken while the controller is idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> (state_reg == S_IDLE))
        else $error("word captured while busy");

    // Every finish returns the controller to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (state_reg == S_IDLE))
        else $error("finish without return to idle");

    // Memory is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.rd_en && cmd.wr_en))
        else $error("read and write collide");

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// Sorted request queue unit testbench
// Drives add, dispatch, remove and neighbor lookup words into the unit and
// checks every result against a behavioral copy of the sorted queue. A short
// directed list covers the empty, absent, no-neighbor, duplicate-tag and
// equal-key cases, and random phases then fill and drain the queue with
// varied gaps between words.
// ----------------------------------------------------------------------------
module tb;

    localparam int DEPTH = 32;
    localparam int WORD_COUNT = 1200;
    localparam int SETTLE_CYCLES = 4 * DEPTH + 16;

    localparam logic [srq_pkg::OP_W-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [srq_pkg::OP_W-1:0] OP_UNUSED_HI = 3'd7;
    localparam logic [srq_pkg::SEC_W-1:0] SECTOR_MAX = '1;
    localparam logic [srq_pkg::LEN_W-1:0] LENGTH_MAX = '1;

    typedef struct {
        srq_pkg::req_t word;
        int unsigned   gap;
        bit            drain;
    } pending_word_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    srq_pkg::req_t  request = '0;
    logic           busy;
    logic           done;
    srq_pkg::rsp_t  result;

    pending_word_t  word_backlog[$];
    srq_pkg::rsp_t  awaited_results[$];
    int             outstanding;
    int             failures;
    int             results_seen;
    int unsigned    waited;
    logic           next_start;
    srq_pkg::req_t  next_req;
    srq_pkg::rsp_t  predicted;

    logic [srq_pkg::KEY_W-1:0] held_key [DEPTH];
    logic [srq_pkg::SEC_W-1:0] held_start [DEPTH];
    logic [srq_pkg::TAG_W-1:0] held_tag [DEPTH];
    int                        held_count;

    sorted_request_queue_unit #(
        .QUEUE_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .done(done),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void drop_entry(input int pos);
        for (int i = pos; i + 1 < held_count; i++)
        begin
            held_key[i] = held_key[i + 1];
            held_start[i] = held_start[i + 1];
            held_tag[i] = held_tag[i + 1];
        end
        held_count--;
    endfunction

    function automatic srq_pkg::rsp_t sorted_queue_apply(input srq_pkg::req_t w);
        srq_pkg::rsp_t             r;
        logic [srq_pkg::KEY_W-1:0] key;
        int                        pos;
        r = '0;
        if (w.operation == srq_pkg::OP_ADD)
        begin
            if (held_count >= DEPTH)
                r.status = srq_pkg::ST_FULL;
            else
            begin
                key = srq_pkg::KEY_W'(w.start_sector) + srq_pkg::KEY_W'(w.length_sectors);
                pos = 0;
                while (pos < held_count && held_key[pos] <= key)
                    pos++;
                for (int i = held_count; i > pos; i--)
                begin
                    held_key[i] = held_key[i - 1];
                    held_start[i] = held_start[i - 1];
                    held_tag[i] = held_tag[i - 1];
                end
                held_key[pos] = key;
                held_start[pos] = w.start_sector;
                held_tag[pos] = w.request_tag;
                held_count++;
            end
        end
        else if (w.operation <= srq_pkg::OP_LATTER)
        begin
            if (held_count == 0)
                r.status = srq_pkg::ST_EMPTY;
            else if (w.operation == srq_pkg::OP_DISPATCH)
            begin
                r.result_tag = held_tag[0];
                r.result_sector = held_start[0];
                drop_entry(0);
            end
            else
            begin
                pos = 0;
                while (pos < held_count && held_tag[pos] != w.request_tag)
                    pos++;
                if (pos >= held_count)
                    r.status = srq_pkg::ST_ABSENT;
                else if (w.operation == srq_pkg::OP_REMOVE)
                    drop_entry(pos);
                else if (w.operation == srq_pkg::OP_FORMER)
                begin
                    if (pos == 0)
                        r.status = srq_pkg::ST_ABSENT;
                    else
                        r.result_tag = held_tag[pos - 1];
                end
                else if (pos + 1 >= held_count)
                    r.status = srq_pkg::ST_ABSENT;
                else
                    r.result_tag = held_tag[pos + 1];
            end
        end
        r.occupancy = srq_pkg::OCC_W'(held_count);
        return r;
    endfunction

    task automatic queue_word(input logic [srq_pkg::OP_W-1:0] op,
                              input logic [srq_pkg::TAG_W-1:0] tag,
                              input logic [srq_pkg::SEC_W-1:0] sec,
                              input logic [srq_pkg::LEN_W-1:0] len,
                              input int unsigned gap, input bit drain);
        pending_word_t p;
        p.word.operation = op;
        p.word.request_tag = tag;
        p.word.start_sector = sec;
        p.word.length_sectors = len;
        p.gap = gap;
        p.drain = drain;
        word_backlog.push_back(p);
    endtask

    // The driver holds a word until it is taken, then counts out the gap of
    // the next one; a draining word also waits for every result to return.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            waited <= 0;
        end
        else
        begin
            next_start = start;
            next_req = request;
            if (start && !busy)
                next_start = 1'b0;
            if (!next_start && word_backlog.size() > 0)
            begin
                if (waited < word_backlog[0].gap)
                    waited <= waited + 1;
                else if (!word_backlog[0].drain || (outstanding == 0 && !(start && !busy)))
                begin
                    next_req = word_backlog[0].word;
                    next_start = 1'b1;
                    void'(word_backlog.pop_front());
                    waited <= 0;
                end
            end
            start <= next_start;
            request <= next_req;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding <= 0;
        else
        begin
            if (done)
            begin
                results_seen++;
                if (awaited_results.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("result %0d arrived with none expected: %p",
                                 results_seen, result);
                end
                else
                begin
                    predicted = awaited_results.pop_front();
                    if (result.status !== predicted.status
                        || result.result_tag !== predicted.result_tag
                        || result.result_sector !== predicted.result_sector
                        || result.occupancy !== predicted.occupancy)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"result %0d: expected st %0d tag %0h sec %0h occ %0d,",
                                      " got st %0d tag %0h sec %0h occ %0d"},
                                     results_seen, predicted.status, predicted.result_tag,
                                     predicted.result_sector, predicted.occupancy,
                                     result.status, result.result_tag,
                                     result.result_sector, result.occupancy);
                    end
                end
            end
            if (start && !busy)
                awaited_results.push_back(sorted_queue_apply(request));
            outstanding <= awaited_results.size();
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int                        counted;
        int                        phase_left;
        int                        add_weight;
        int                        gap_mode;
        int unsigned               gap;
        logic [srq_pkg::OP_W-1:0]  op;
        logic [srq_pkg::TAG_W-1:0] tag;
        logic [srq_pkg::SEC_W-1:0] sec;
        logic [srq_pkg::LEN_W-1:0] len;
        bit                        drain;

        held_count = 0;
        failures = 0;
        results_seen = 0;

        queue_word(srq_pkg::OP_DISPATCH, 8'd0, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_REMOVE, 8'd0, '0, '0, 3, 1'b0);
        queue_word(srq_pkg::OP_FORMER, 8'd255, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_LATTER, 8'd1, '0, '0, 1, 1'b0);
        queue_word(OP_UNUSED_LO, 8'd255, SECTOR_MAX, LENGTH_MAX, 0, 1'b0);
        queue_word(OP_UNUSED_LO + 3'd1, 8'd0, '0, '0, 2, 1'b0);
        queue_word(OP_UNUSED_HI, 8'd3, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_ADD, 8'd255, SECTOR_MAX, LENGTH_MAX, 0, 1'b0);
        queue_word(srq_pkg::OP_ADD, 8'd0, '0, '0, 5, 1'b0);
        queue_word(srq_pkg::OP_ADD, 8'd7, 48'd100, 16'd0, 0, 1'b0);
        queue_word(srq_pkg::OP_ADD, 8'd8, 48'd90, 16'd10, 0, 1'b0);
        queue_word(srq_pkg::OP_ADD, 8'd7, 48'd50, 16'd5, 0, 1'b0);
        queue_word(srq_pkg::OP_FORMER, 8'd7, '0, '0, 0, 1'b1);
        queue_word(srq_pkg::OP_FORMER, 8'd0, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_LATTER, 8'd255, '0, '0, 4, 1'b0);
        queue_word(srq_pkg::OP_LATTER, 8'd8, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_FORMER, 8'd255, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_REMOVE, 8'd99, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_FORMER, 8'd99, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_LATTER, 8'd99, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_REMOVE, 8'd7, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_DISPATCH, 8'd0, '0, '0, 0, 1'b0);
        queue_word(srq_pkg::OP_DISPATCH, 8'd0, '0, '0, 7, 1'b0);
        queue_word(OP_UNUSED_LO, 8'd0, '0, '0, 0, 1'b0);

        // Random phases lean toward filling, draining or neither, so the
        // queue runs repeatedly between empty and full.
        counted = 0;
        phase_left = 0;
        add_weight = 50;
        gap_mode = 0;
        drain = 1'b1;
        while (counted < WORD_COUNT)
        begin
            if (phase_left == 0)
            begin
                phase_left = $urandom_range(20, 80);
                case ($urandom_range(0, 2))
                    0: add_weight = 80;
                    1: add_weight = 20;
                    default: add_weight = 50;
                endcase
                gap_mode = $urandom_range(0, 2);
                if ($urandom_range(0, 2) == 0)
                    drain = 1'b1;
            end
            phase_left--;

            if ($urandom_range(0, 99) < 3)
                op = srq_pkg::OP_LATTER
                     + 3'($urandom_range(1, OP_UNUSED_HI - srq_pkg::OP_LATTER));
            else if ($urandom_range(0, 99) < add_weight)
                op = srq_pkg::OP_ADD;
            else
                op = 3'($urandom_range(srq_pkg::OP_DISPATCH, srq_pkg::OP_LATTER));

            if ($urandom_range(0, 9) == 0)
                tag = srq_pkg::TAG_W'($urandom);
            else
                tag = srq_pkg::TAG_W'($urandom_range(0, 15));

            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: sec = srq_pkg::SEC_W'($urandom_range(0, 40));
                5: sec = SECTOR_MAX - srq_pkg::SEC_W'($urandom_range(0, 40));
                default: sec = srq_pkg::SEC_W'({$urandom, $urandom});
            endcase
            if ($urandom_range(0, 1) == 0)
                len = srq_pkg::LEN_W'($urandom_range(0, 4));
            else
                len = srq_pkg::LEN_W'($urandom);

            case (gap_mode)
                0: gap = 0;
                1: gap = $urandom_range(0, 14);
                default: gap = $urandom_range(0, 2);
            endcase

            queue_word(op, tag, sec, len, gap, drain);
            drain = 1'b0;
            if (op <= srq_pkg::OP_LATTER)
                counted++;
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        do
            @(negedge clk);
        while (word_backlog.size() > 0 || start || outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && awaited_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/srq_pkg.sv
design/srq_datapath.sv
design/srq_controller.sv
design/sorted_request_queue_unit.sv
tb/sv/tb.sv
